[rtl/pcr_pkg.sv]
package pcr_pkg;

    localparam int PALETTE_SIZE_DEF = 256;
    localparam int CH_W             = 8;
    localparam int SQ_W             = 2 * CH_W;
    localparam int DIST_W           = 18;
    localparam int IDX_OUT_W        = 8;

    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(3 * 255 * 255);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color;

    // status of the distance pipeline toward the sequencer
    typedef struct packed {
        logic vld;
        logic busy;
    } t_dist_st;

endpackage

[rtl/pcr_if.sv]
interface pcr_req_if;
    logic                    valid;
    logic                    ready;
    logic [pcr_pkg::CH_W-1:0] red;
    logic [pcr_pkg::CH_W-1:0] green;
    logic [pcr_pkg::CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface pcr_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pcr_pkg::IDX_OUT_W-1:0] palette_index;
    logic                         new_color;

    modport source (output valid, output palette_index, output new_color, input ready);
    modport sink   (input valid, input palette_index, input new_color, output ready);
endinterface

[rtl/palette_color_resolve.sv]
// Palette color resolver.
// Request channel i_req carries one RGB color (red, green, blue, 8 bits each).
// Response channel o_rsp returns palette_index and new_color, one per request.
// The color is compared against the stored palette entries in index order by
// squared Euclidean distance. An exact match returns its index at once; else
// the color is appended and flagged new; with a full palette the closest
// entry is returned, ties to the lowest index.
// Entries are read one per cycle from the single palette memory read port and
// pass through the read register and the square and sum registers of the
// distance pipeline; then the scan closes and the output register loads. An
// exact match ends the scan early; an empty palette has nothing to compare.
// The next request can be taken in the cycle after the response loads.
// i_req.ready is high only while the sequencer is idle; one request is in work
// at a time. A finished response waits in the output register while the next
// request is taken; when the receiver stalls, the next response holds in the
// finish state until the output register frees.
// Reset clears the entry count and the handshake state; palette contents are
// not cleared, since only entries below the count are ever compared.
module palette_color_resolve #(
    parameter int PALETTE_SIZE = pcr_pkg::PALETTE_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pcr_req_if.sink          i_req,
    pcr_rsp_if.source        o_rsp
);

    localparam int IDX_W = $clog2(PALETTE_SIZE);
    localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
    localparam int EXT_W = (IDX_W > pcr_pkg::IDX_OUT_W) ? IDX_W : pcr_pkg::IDX_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                     r_state;
    pcr_pkg::t_color            r_color;
    pcr_pkg::t_color            r_rd_data;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_issue;
    logic [IDX_W-1:0]           r_cmp_idx;
    logic [IDX_W-1:0]           r_best;
    logic [pcr_pkg::DIST_W-1:0] r_best_dist;
    logic                       r_p1_vld;
    logic [IDX_W-1:0]           r_res_idx;
    logic                       r_res_new;
    logic                       r_out_vld;
    logic [pcr_pkg::IDX_OUT_W-1:0] r_out_idx;
    logic                       r_out_new;

    pcr_pkg::t_color            mem [PALETTE_SIZE];

    logic [pcr_pkg::DIST_W-1:0] ent_dist;
    pcr_pkg::t_dist_st          dst;
    logic                       accept;
    logic                       issue;
    logic                       hit;
    logic                       full;
    logic                       scan_done;
    logic                       mem_we;
    logic                       out_load;
    logic [CNT_W-1:0]           n_count;
    logic [EXT_W-1:0]           res_ext;

    assign accept    = i_req.valid && i_req.ready;
    assign issue     = (r_state == S_SCAN) && (r_issue != r_count);
    assign hit       = (r_state == S_SCAN) && dst.vld;
    assign full      = (r_count == CNT_W'(PALETTE_SIZE));
    // every stored entry issued and the distance pipeline drained
    assign scan_done = (r_state == S_SCAN) && (r_issue == r_count) && !r_p1_vld && !dst.busy;
    assign mem_we    = scan_done && !full;
    assign out_load  = (r_state == S_FINISH) && (!r_out_vld || o_rsp.ready);
    assign n_count   = r_count + CNT_W'(1);
    assign res_ext   = EXT_W'(r_res_idx);

    // palette memory: one write for allocation, one registered read for the scan
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= r_color;
        end
        r_rd_data <= mem[r_issue[IDX_W-1:0]];
    end

    pcr_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p1_vld),
        .i_flush (r_state != S_SCAN),
        .i_entry (r_rd_data),
        .i_color (r_color),
        .o_dist  (ent_dist),
        .o_st    (dst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_p1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_p1_vld <= issue;
            if (out_load) begin
                r_out_vld <= 1'b1;
                r_out_idx <= res_ext[pcr_pkg::IDX_OUT_W-1:0];
                r_out_new <= r_res_new;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_color.red   <= i_req.red;
                        r_color.green <= i_req.green;
                        r_color.blue  <= i_req.blue;
                        r_issue       <= '0;
                        r_cmp_idx     <= '0;
                        r_best        <= '0;
                        r_best_dist   <= pcr_pkg::MAX_DIST;
                        r_state       <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_issue <= r_issue + CNT_W'(1);
                    end
                    if (hit) begin
                        r_cmp_idx <= r_cmp_idx + IDX_W'(1);
                        if (ent_dist == '0) begin
                            // exact match: drop the rest of the scan
                            r_res_idx <= r_cmp_idx;
                            r_res_new <= 1'b0;
                            r_state   <= S_FINISH;
                        end else if (ent_dist < r_best_dist) begin
                            r_best_dist <= ent_dist;
                            r_best      <= r_cmp_idx;
                        end
                    end else if (scan_done) begin
                        if (full) begin
                            r_res_idx <= r_best;
                            r_res_new <= 1'b0;
                        end else begin
                            r_res_idx <= r_count[IDX_W-1:0];
                            r_res_new <= 1'b1;
                            r_count   <= n_count;
                        end
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.palette_index = r_out_idx;
    assign o_rsp.new_color     = r_out_new;

endmodule

[rtl/pcr_dist.sv]
module pcr_dist (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_vld,
    input  logic                             i_flush,
    input  pcr_pkg::t_color                  i_entry,
    input  pcr_pkg::t_color                  i_color,
    output logic [pcr_pkg::DIST_W-1:0]       o_dist,
    output pcr_pkg::t_dist_st                o_st
);

    function automatic logic [pcr_pkg::CH_W-1:0] abs_diff(
        input logic [pcr_pkg::CH_W-1:0] a,
        input logic [pcr_pkg::CH_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [pcr_pkg::CH_W-1:0]   dr, dg, db;
    logic [pcr_pkg::SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    logic [pcr_pkg::DIST_W-1:0] r_dist;
    logic                       r_s1_vld, r_s2_vld;

    assign dr = abs_diff(i_entry.red,   i_color.red);
    assign dg = abs_diff(i_entry.green, i_color.green);
    assign db = abs_diff(i_entry.blue,  i_color.blue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    // square the channel differences, then sum them
    always_ff @(posedge i_clk) begin
        r_sq_r <= pcr_pkg::SQ_W'(dr) * pcr_pkg::SQ_W'(dr);
        r_sq_g <= pcr_pkg::SQ_W'(dg) * pcr_pkg::SQ_W'(dg);
        r_sq_b <= pcr_pkg::SQ_W'(db) * pcr_pkg::SQ_W'(db);
        r_dist <= pcr_pkg::DIST_W'(r_sq_r) + pcr_pkg::DIST_W'(r_sq_g)
                + pcr_pkg::DIST_W'(r_sq_b);
    end

    assign o_dist    = r_dist;
    assign o_st.vld  = r_s2_vld;
    assign o_st.busy = r_s1_vld | r_s2_vld;

endmodule

[rtl/pcr_checker.sv]
module pcr_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [pcr_pkg::IDX_OUT_W-1:0]     i_palette_index,
    input  logic                              i_new_color
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // requests taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_palette_index) && $stable(i_new_color))
        else $error("stalled response changed");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("request taken while previous one is in work");

    a_rsp_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("response without a pending request");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_pend <= 2'd1)
        else $error("more than two requests outstanding");

endmodule

bind palette_color_resolve pcr_checker u_pcr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_palette_index (o_rsp.palette_index),
    .i_new_color     (o_rsp.new_color)
);

[bench/palette_color_resolve_chk.sv]
`timescale 1ns / 1ps
module palette_color_resolve_chk (
    input  logic i_clk,
    input  logic i_rst_n,
    pcr_req_if   i_req,
    pcr_rsp_if   i_rsp,
    output int   o_fail_cnt,
    output int   o_pending
);

    localparam int CAPACITY = pcr_pkg::PALETTE_SIZE_DEF;

    typedef struct packed {
        logic [pcr_pkg::IDX_OUT_W-1:0] palette_index;
        logic                          new_color;
    } t_resolved;

    // shadow palette, filled in the same order as the block fills its own
    pcr_pkg::t_color shadow_palette [CAPACITY];
    int unsigned     shadow_cnt   = 0;
    t_resolved       resolved_q [$];
    int              mismatch_cnt = 0;
    int              pending_cnt  = 0;
    int              rsp_cnt      = 0;

    assign o_fail_cnt = mismatch_cnt;
    assign o_pending  = pending_cnt;

    task automatic report_mismatch(input string msg);
        $display("%0t ns resolve check: %s", $time, msg);
        mismatch_cnt++;
    endtask

    function automatic int unsigned chan_sq(
        input logic [pcr_pkg::CH_W-1:0] a,
        input logic [pcr_pkg::CH_W-1:0] b
    );
        int unsigned d;
        d = (a >= b) ? a - b : b - a;
        return d * d;
    endfunction

    // Resolve one color against the shadow palette; append it when it is new
    // and there is room.
    function automatic t_resolved resolve_color(input pcr_pkg::t_color c);
        int unsigned best_dist;
        int unsigned best_idx;
        int unsigned cand_dist;
        int unsigned i;
        t_resolved   res;
        best_dist = pcr_pkg::MAX_DIST;
        best_idx  = 0;
        for (i = 0; i < shadow_cnt; i++) begin
            cand_dist = chan_sq(shadow_palette[i].red, c.red)
                      + chan_sq(shadow_palette[i].green, c.green)
                      + chan_sq(shadow_palette[i].blue, c.blue);
            if (cand_dist < best_dist) begin
                if (cand_dist == 0) begin
                    res.palette_index = pcr_pkg::IDX_OUT_W'(i);
                    res.new_color     = 1'b0;
                    return res;
                end
                best_dist = cand_dist;
                best_idx  = i;
            end
        end
        if (shadow_cnt >= CAPACITY) begin
            res.palette_index = pcr_pkg::IDX_OUT_W'(best_idx);
            res.new_color     = 1'b0;
            return res;
        end
        shadow_palette[shadow_cnt] = c;
        res.palette_index = pcr_pkg::IDX_OUT_W'(shadow_cnt);
        res.new_color     = 1'b1;
        shadow_cnt++;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_resolved want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                resolved_q.push_back(resolve_color(
                    pcr_pkg::t_color'({i_req.red, i_req.green, i_req.blue})));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                rsp_cnt++;
                if (resolved_q.size() == 0) begin
                    report_mismatch($sformatf("response %0d with no request outstanding",
                                              rsp_cnt));
                end else begin
                    want = resolved_q.pop_front();
                    if (i_rsp.palette_index !== want.palette_index) begin
                        report_mismatch($sformatf("response %0d palette_index %0d, want %0d",
                                                  rsp_cnt, i_rsp.palette_index,
                                                  want.palette_index));
                    end
                    if (i_rsp.new_color !== want.new_color) begin
                        report_mismatch($sformatf("response %0d new_color %0b, want %0b",
                                                  rsp_cnt, i_rsp.new_color, want.new_color));
                    end
                end
            end
            pending_cnt = resolved_q.size();
        end
    end

endmodule

[bench/palette_color_resolve_tb.sv]
`timescale 1ns / 1ps
module palette_color_resolve_tb;

    localparam int CAPACITY        = pcr_pkg::PALETTE_SIZE_DEF;
    localparam int ITEM_TOTAL      = 550;
    // from this request on, neither side idles
    localparam int CALM_FROM       = 480;
    // the receiver holds off once, early, while the palette is still small
    localparam int HOLD_OFF_AT     = 60;
    localparam int HOLD_OFF_CYCLES = 1200;
    // the sender drains the block once
    localparam int PAUSE_AT        = 320;
    localparam int DRAIN_CYCLES    = 600;
    // longest quiet stretch: hold-off plus one full scan, with margin
    localparam int STALL_LIMIT     = 6000;

    // Opening colors: extremes of every channel, exact repeats, one-bit
    // steps, alternating bit patterns. White against black sits exactly at
    // the maximum distance.
    localparam logic [23:0] DIRECTED_COLORS [22] = '{
        24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h00FFFF,
        24'hFF00FF, 24'hFFFF00, 24'h010101, 24'h808080,
        24'h7F7F7F, 24'hFEFEFE, 24'h010000, 24'h000100,
        24'h000001, 24'h808080, 24'hAA55AA, 24'h55AA55,
        24'hFF0000, 24'h7F7F7F
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pcr_req_if req_ch ();
    pcr_rsp_if rsp_ch ();

    int fail_cnt;
    int pending_cnt;

    int              sent_cnt      = 0;
    int              quiet_cycles  = 0;
    bit              hold_off_done = 1'b0;
    pcr_pkg::t_color known_q [$];           // distinct colors sent so far
    bit              color_seen [bit [23:0]];

    palette_color_resolve u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    palette_color_resolve_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .i_rsp      (rsp_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending_cnt)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one color, called at a falling edge; return at the falling edge
    // after the request is taken. Valid stays high between requests except for
    // the random idle gaps drawn before CALM_FROM.
    task automatic send_color(input pcr_pkg::t_color c);
        if (sent_cnt < CALM_FROM && $urandom_range(0, 3) == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.red   = c.red;
        req_ch.green = c.green;
        req_ch.blue  = c.blue;
        do begin
            @(posedge i_clk);
        end while (req_ch.ready !== 1'b1);
        if (!color_seen.exists(c)) begin
            color_seen[c] = 1'b1;
            known_q.push_back(c);
        end
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // Step a channel by a few counts, clamped to its range.
    function automatic logic [pcr_pkg::CH_W-1:0] nudge(input logic [pcr_pkg::CH_W-1:0] v);
        int t;
        t = int'(v) + int'($urandom_range(0, 6)) - 3;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return pcr_pkg::CH_W'(t);
    endfunction

    // Request side: reset, opening colors, then the random mix.
    initial begin
        pcr_pkg::t_color c;
        pcr_pkg::t_color base;
        int unsigned     pick;
        int unsigned     step;
        req_ch.valid = 1'b0;
        req_ch.red   = '0;
        req_ch.green = '0;
        req_ch.blue  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED_COLORS[k]) begin
            send_color(pcr_pkg::t_color'(DIRECTED_COLORS[k]));
        end

        while (sent_cnt < ITEM_TOTAL) begin
            // drain the block once
            if (sent_cnt == PAUSE_AT) begin
                req_ch.valid = 1'b0;
                while (pending_cnt != 0) @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 25 && known_q.size() > 0) begin
                // exact repeat of a color sent before
                c = known_q[$urandom_range(0, known_q.size() - 1)];
            end else if (pick < 45) begin
                // coarse lattice while filling; once full, probe at half the
                // spacing so that lattice neighbors tie on distance
                step = (known_q.size() < CAPACITY) ? 64 : 32;
                c.red   = pcr_pkg::CH_W'($urandom_range(0, 256 / step - 1) * step);
                c.green = pcr_pkg::CH_W'($urandom_range(0, 256 / step - 1) * step);
                c.blue  = pcr_pkg::CH_W'($urandom_range(0, 256 / step - 1) * step);
            end else if (pick < 60 && known_q.size() > 0) begin
                // close neighbor of a color sent before
                base    = known_q[$urandom_range(0, known_q.size() - 1)];
                c.red   = nudge(base.red);
                c.green = nudge(base.green);
                c.blue  = nudge(base.blue);
            end else begin
                c = pcr_pkg::t_color'(24'($urandom()));
            end
            send_color(c);
        end
        req_ch.valid = 1'b0;

        // hold until every response is in, then watch for strays
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("palette_color_resolve: match");
        end else begin
            $display("palette_color_resolve: mismatch");
        end
        $finish;
    end

    // Response side: random ready bursts, one long hold-off so the block
    // backs up into its request port, and no stalls in the closing stretch.
    initial begin
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (sent_cnt >= CALM_FROM) begin
                rsp_ch.ready = 1'b1;
                @(negedge i_clk);
            end else if (!hold_off_done && sent_cnt >= HOLD_OFF_AT) begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end else begin
                rsp_ch.ready = 1'b1;
                repeat ($urandom_range(1, 60)) @(negedge i_clk);
            end
        end
    end

    // Watchdog: drop the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("palette_color_resolve: mismatch");
            $finish;
        end
    end

endmodule
